/* src/indexed_ring_sequence_core_assert.svh */
// Assertion macros shared by the RTL files.
`ifndef INDEXED_RING_SEQUENCE_CORE_ASSERT_SVH
`define INDEXED_RING_SEQUENCE_CORE_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define IRS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define IRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/irs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package irs_pkg;
  localparam int Capacity = 64;
  localparam int ValueWidth = 32;
  localparam int SlotWidth = $clog2(Capacity);
  localparam int CountWidth = $clog2(Capacity + 1);

  localparam logic [3:0] FUNC_CLEAR = 4'd0;
  localparam logic [3:0] FUNC_GET = 4'd1;
  localparam logic [3:0] FUNC_PUT = 4'd2;
  localparam logic [3:0] FUNC_ADD_AT = 4'd3;
  localparam logic [3:0] FUNC_ADD_FRONT = 4'd4;
  localparam logic [3:0] FUNC_ADD_BACK = 4'd5;
  localparam logic [3:0] FUNC_REMOVE_AT = 4'd6;
  localparam logic [3:0] FUNC_REMOVE_FRONT = 4'd7;
  localparam logic [3:0] FUNC_REMOVE_BACK = 4'd8;
  localparam logic [3:0] FUNC_ROTATE = 4'd9;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef logic [3:0] op_t;
  localparam op_t OP_NONE = 4'd0;
  localparam op_t OP_CLEAR = 4'd1;
  localparam op_t OP_READ = 4'd2;
  localparam op_t OP_WRITE = 4'd3;
  localparam op_t OP_INSERT = 4'd4;
  localparam op_t OP_REMOVE = 4'd5;
  localparam op_t OP_ROTATE = 4'd6;
  localparam op_t OP_FAIL = 4'd7;

  // Word passed from the front end to the back end. The front end only
  // queues; range checks need the live count and are done in the back end.
  typedef struct packed {
    logic [3:0] func;
    logic signed [7:0] position;
    logic [ValueWidth-1:0] item_value;
  } cmd_t;
endpackage
`default_nettype wire

/* src/irs_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface irs_in_if;
  logic valid;
  logic ready;
  logic [3:0] func;
  logic signed [7:0] position;
  logic [irs_pkg::ValueWidth-1:0] item_value;
  modport source (output valid, func, position, item_value, input ready);
  modport sink (input valid, func, position, item_value, output ready);
endinterface
`default_nettype wire

/* src/irs_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface irs_out_if;
  logic valid;
  logic ready;
  logic [31:0] result_value;
  logic [irs_pkg::CountWidth-1:0] count;
  logic [1:0] status;
  modport source (output valid, result_value, count, status, input ready);
  modport sink (input valid, result_value, count, status, output ready);
endinterface
`default_nettype wire

/* src/irs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module irs_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(Depth)-1:0] waddr,
  input wire logic [Width-1:0] wdata,
  input wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/irs_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// Two-entry command queue between the input channel and the back end.
module irs_front (
  input wire logic clk,
  input wire logic rst,
  irs_in_if.sink in_ch,
  output irs_pkg::cmd_t cmd,
  output logic cmd_valid,
  input wire logic cmd_take
);
  irs_pkg::cmd_t q [2];
  logic [1:0] fill;
  logic rd_ptr, wr_ptr;
  logic push;

  assign in_ch.ready = (fill != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign cmd_valid = (fill != 2'd0);
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= '{in_ch.func, in_ch.position, in_ch.item_value};
    if (rst) begin
      fill <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_take && cmd_valid) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, cmd_take && cmd_valid};
    end
  end

`include "indexed_ring_sequence_core_assert.svh"
  `IRS_ASSERT_IMPL(a_no_overflow, fill == 2'd2, !push)
  `IRS_ASSERT_IMPL(a_fill_range, 1'b1, fill != 2'd3)
  `IRS_ASSERT_IMPL(a_take_valid, cmd_take, cmd_valid)
endmodule
`default_nettype wire

/* src/irs_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// Executes one command at a time; element moves go one slot at a time,
// each through S_MOVE and S_MWAIT, via the single-port-read RAM.
module irs_back (
  input wire logic clk,
  input wire logic rst,
  input wire irs_pkg::cmd_t cmd,
  input wire logic cmd_valid,
  output logic cmd_take,
  irs_out_if.source out_ch
);
  localparam int SW = irs_pkg::SlotWidth;
  localparam int CW = irs_pkg::CountWidth;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_RWAIT = 6'b000100,
    S_MOVE = 6'b001000,
    S_MWAIT = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;
  logic [SW-1:0] first;
  logic [CW-1:0] len;
  irs_pkg::cmd_t c;
  irs_pkg::op_t op;
  logic [1:0] st;
  logic [CW-1:0] idx;     // logical target index
  logic [CW-1:0] k;       // move cursor
  logic [31:0] res;

  logic we;
  logic [SW-1:0] waddr, raddr;
  logic [irs_pkg::ValueWidth-1:0] wdata, rdata;

  irs_ram #(.Width(irs_pkg::ValueWidth), .Depth(irs_pkg::Capacity)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Decode against live state
  logic signed [CW+1:0] p, sl;
  logic full, empty;
  irs_pkg::op_t dop;
  logic [1:0] dst;
  logic [CW-1:0] didx;
  always_comb begin
    p = (CW+2)'(c.position);
    sl = (CW+2)'({1'b0, len});
    full = (len == CW'(irs_pkg::Capacity));
    empty = (len == '0);
    dop = irs_pkg::OP_NONE;
    dst = irs_pkg::ST_OK;
    didx = '0;
    unique case (c.func) inside
      irs_pkg::FUNC_CLEAR: dop = irs_pkg::OP_CLEAR;
      irs_pkg::FUNC_GET, irs_pkg::FUNC_PUT, irs_pkg::FUNC_REMOVE_AT: begin
        if (empty) dst = irs_pkg::ST_EMPTY;
        else if (p < 0 || p >= sl) dst = irs_pkg::ST_RANGE;
        else begin
          didx = CW'(p);
          dop = (c.func == irs_pkg::FUNC_GET) ? irs_pkg::OP_READ :
                (c.func == irs_pkg::FUNC_PUT) ? irs_pkg::OP_WRITE : irs_pkg::OP_REMOVE;
        end
      end
      irs_pkg::FUNC_ADD_AT: begin
        if (full) dst = irs_pkg::ST_FULL;
        else if (p < -sl || p > sl + 1) dst = irs_pkg::ST_RANGE;
        else begin
          dop = irs_pkg::OP_INSERT;
          if (p == 1 || p == -sl) didx = '0;
          else if (p == 0 || p == sl + 1) didx = len;
          else if (p < 0) didx = CW'(p + sl);
          else didx = CW'(p - 1);
        end
      end
      irs_pkg::FUNC_ADD_FRONT, irs_pkg::FUNC_ADD_BACK: begin
        if (full) dst = irs_pkg::ST_FULL;
        else begin
          dop = irs_pkg::OP_INSERT;
          didx = (c.func == irs_pkg::FUNC_ADD_FRONT) ? '0 : len;
        end
      end
      irs_pkg::FUNC_REMOVE_FRONT, irs_pkg::FUNC_REMOVE_BACK: begin
        if (empty) dst = irs_pkg::ST_EMPTY;
        else begin
          dop = irs_pkg::OP_REMOVE;
          didx = (c.func == irs_pkg::FUNC_REMOVE_FRONT) ? '0 : len - 1'b1;
        end
      end
      irs_pkg::FUNC_ROTATE: begin
        if (empty) dst = irs_pkg::ST_EMPTY;
        else if (p < -sl || p > sl) dst = irs_pkg::ST_RANGE;
        else begin
          dop = irs_pkg::OP_ROTATE;
          // n == len wraps to 0
          if (p < 0) didx = CW'(p + sl);
          else if (p == sl) didx = '0;
          else didx = CW'(p);
        end
      end
      default: dop = irs_pkg::OP_NONE;
    endcase
    if (dst != irs_pkg::ST_OK) dop = irs_pkg::OP_FAIL;
  end

  function automatic logic [SW-1:0] slot(input logic [SW-1:0] f, input logic [CW-1:0] i);
    slot = f + SW'(i);
  endfunction

  logic inserting;
  assign inserting = (op == irs_pkg::OP_INSERT);
  assign cmd_take = (state == S_IDLE) && cmd_valid;
  logic loaded;

  // Read address: insert shifts up reading k-1; remove shifts down reading k+1
  always_comb begin
    raddr = slot(first, idx);
    if (state == S_MOVE) raddr = inserting ? slot(first, k - 1'b1) : slot(first, k + 1'b1);
    we = 1'b0;
    waddr = slot(first, k);
    wdata = rdata;
    if (state == S_MWAIT) we = 1'b1;
    if (state == S_READ && loaded) begin
      we = (op == irs_pkg::OP_WRITE) || (op == irs_pkg::OP_INSERT &&
            (k == idx || idx == '0));
      waddr = (op == irs_pkg::OP_INSERT && idx == '0) ? first - 1'b1 : slot(first, idx);
      wdata = c.item_value;
    end
  end

  assign out_ch.valid = (state == S_DONE);
  assign out_ch.result_value = res;
  assign out_ch.count = len;
  assign out_ch.status = st;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first <= '0;
      len <= '0;
      loaded <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          loaded <= 1'b0;
          if (cmd_valid) begin
            c <= cmd;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (!loaded) begin
            op <= dop;
            st <= dst;
            idx <= didx;
            res <= '0;
            loaded <= 1'b1;
            if (dop == irs_pkg::OP_INSERT) k <= len;
            else k <= didx;
            if (dop == irs_pkg::OP_CLEAR) begin
              first <= '0;
              len <= '0;
              state <= S_DONE;
            end else if (dop == irs_pkg::OP_NONE || dop == irs_pkg::OP_FAIL) begin
              state <= S_DONE;
            end else if (dop == irs_pkg::OP_ROTATE) begin
              first <= slot(first, didx);
              state <= S_DONE;
            end
          end else begin
            // raddr = slot(idx) issued now; data next cycle
            if (op == irs_pkg::OP_INSERT) begin
              res <= c.item_value;
              if (idx == '0) begin
                first <= first - 1'b1;
                len <= len + 1'b1;
                state <= S_DONE;
              end else if (k == idx) begin
                len <= len + 1'b1;
                state <= S_DONE;
              end else state <= S_MOVE;
            end else state <= S_RWAIT;
          end
        end
        S_RWAIT: begin
          res <= rdata;
          if (op == irs_pkg::OP_REMOVE) begin
            if (idx == '0) begin
              first <= (len == CW'(1)) ? '0 : first + 1'b1;
              len <= len - 1'b1;
              state <= S_DONE;
            end else if (k + 1'b1 >= len) begin
              len <= len - 1'b1;
              state <= S_DONE;
            end else state <= S_MOVE;
          end else state <= S_DONE;
        end
        S_MOVE: state <= S_MWAIT;
        S_MWAIT: begin
          // write done this cycle at slot(k)
          if (inserting) begin
            if (k - 1'b1 == idx) begin
              k <= idx;
              state <= S_READ; // final write of new value
            end else begin
              k <= k - 1'b1;
              state <= S_MOVE;
            end
          end else begin
            if (k + CW'(2) >= len) begin
              len <= len - 1'b1;
              if (len == CW'(1)) first <= '0;
              state <= S_DONE;
            end else begin
              k <= k + 1'b1;
              state <= S_MOVE;
            end
          end
        end
        S_DONE: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "indexed_ring_sequence_core_assert.svh"
  `IRS_ASSERT_IMPL(a_len_cap, 1'b1, len <= CW'(irs_pkg::Capacity))
  `IRS_ASSERT_IMPL(a_fail_zero, state == S_DONE && st != irs_pkg::ST_OK, res == '0)
  `IRS_ASSERT_NEXT(a_hold, state == S_DONE && !out_ch.ready, state == S_DONE)
endmodule
`default_nettype wire

/* src/indexed_ring_sequence_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Indexed ring sequence: a deque of up to 64 32-bit handles with indexed
// get/put/insert/remove and rotate.
// Channels: in_ch (func, position, item_value) and out_ch (result_value,
// count, status), valid/ready; a word moves when both are high.
// Every input word yields exactly one output word, in order.
// Clear, rotate, unused codes and errors finish without a RAM access;
// add front/back does one RAM write, get/remove front/back a registered
// read, put a write and a read; insert or remove in the middle also
// shifts elements one slot at a time. One command executes at a time in
// the back end; the RAM's single registered read port sets the shift rate.
// A two-word queue in front keeps accepting while a result is held.
// Reset (synchronous rst) empties the sequence; the store needs no clearing.
// When the receiver holds ready low the result stays put and the queue
// fills, then in_ch.ready drops.
module indexed_ring_sequence_core (
  input wire logic clk,
  input wire logic rst,
  irs_in_if.sink in_ch,
  irs_out_if.source out_ch
);
  irs_pkg::cmd_t cmd;
  logic cmd_valid, cmd_take;

  irs_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
  );

  irs_back u_back (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid),
    .cmd_take(cmd_take), .out_ch(out_ch)
  );
endmodule
`default_nettype wire
